// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the ATR parser.
// No dependencies; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/atr_pkg.sv
// Types, codes and constants of the ATR structure parser.
// No dependencies; imported by every module of the block.
package atr_pkg;

  localparam int unsigned MAX_ATR_BYTES_DEF = 33;
  localparam int unsigned IDX_W = 6;

  // Parser phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_T0    = 3'd1;
  localparam logic [2:0] PH_IFACE = 3'd2;
  localparam logic [2:0] PH_HIST  = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;

  // Byte classes
  localparam logic [2:0] CL_TS    = 3'd0;
  localparam logic [2:0] CL_T0    = 3'd1;
  localparam logic [2:0] CL_TA    = 3'd2;
  localparam logic [2:0] CL_TB    = 3'd3;
  localparam logic [2:0] CL_TC    = 3'd4;
  localparam logic [2:0] CL_TD    = 3'd5;
  localparam logic [2:0] CL_HIST  = 3'd6;
  localparam logic [2:0] CL_CHECK = 3'd7;

  // Error codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_REMOVED  = 2'd2;
  localparam logic [1:0] ERR_OUTSIDE  = 2'd3;

  localparam logic [3:0] LEVEL_MAX = 4'hf;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       first_byte;
    logic       card_present;
  } atr_in_t;

  typedef struct packed {
    logic [2:0]       byte_class;
    logic [3:0]       interface_level;
    logic [IDX_W-1:0] byte_index;
    logic             atr_done;
    logic [1:0]       error_code;
  } atr_out_t;

  typedef struct packed {
    logic [2:0]       phase;
    logic [3:0]       pending_mask;
    logic [3:0]       hist_left;
    logic [IDX_W-1:0] byte_count;
    logic [3:0]       group_level;
  } atr_state_t;

  // Phase that follows once the pending interface bytes and history are known.
  function automatic logic [2:0] next_phase(input logic [3:0] mask, input logic [3:0] hist);
    logic [2:0] ph;
    if (mask != 4'd0) ph = PH_IFACE;
    else if (hist != 4'd0) ph = PH_HIST;
    else ph = PH_CHECK;
    return ph;
  endfunction

endpackage

// File: rtl/atr_structure_parser.sv
// Top level of the ATR structure parser: parse state and result register.
// Depends on atr_pkg and atr_step.
//
//   channel  | ports                            | word
//   ---------+----------------------------------+----------------------------
//   input    | in_valid, in_ready, in_data      | one ATR byte with flags
//   result   | out_valid, out_ready, out_data   | label of that byte
//
// One byte per cycle while the result side does not stall: each accepted
// byte is labelled by atr_step in the same cycle and its label lands in the
// result register at the accepting edge, so out_valid rises in the cycle after.
// Reset (rst_n low, synchronous) returns the parser to idle, awaiting TS.
// in_ready stays high while the result register is empty or being taken,
// so a stalled result holds the input side and the parse state with it.
module atr_structure_parser
  import atr_pkg::*;
#(
  parameter int unsigned MAX_ATR_BYTES = MAX_ATR_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  atr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output atr_out_t out_data
);

  atr_state_t st_r, st_nxt;
  atr_out_t   res_nxt, out_data_r;
  logic       out_valid_r;
  logic       in_fire;

  // Take a new byte whenever the result slot is free or is being emptied.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  atr_step #(
    .MAX_ATR_BYTES(MAX_ATR_BYTES)
  ) u_step (
    .in_word(in_data),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Advance the parse state only on an accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDLE, default: '0};
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // Result valid: set on acceptance, drop once taken with nothing behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: load with each accepted byte, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/atr_step.sv
// Next-state and result logic for one ATR byte.
// Depends on atr_pkg.
module atr_step
  import atr_pkg::*;
#(
  parameter int unsigned MAX_ATR_BYTES = MAX_ATR_BYTES_DEF
) (
  input  atr_in_t    in_word,
  input  atr_state_t st,
  output atr_state_t st_nxt,
  output atr_out_t   res
);

  localparam logic [IDX_W-1:0] MaxIdx = IDX_W'(MAX_ATR_BYTES);

  atr_state_t idle_st;
  logic [1:0] k;
  logic [3:0] mask_clr;
  logic [3:0] hi_nib;
  logic [3:0] lo_nib;

  assign hi_nib = in_word.rx_byte[7:4];
  assign lo_nib = in_word.rx_byte[3:0];

  always_comb begin
    idle_st = '0;
    idle_st.phase = PH_IDLE;
  end

  // Lowest pending of TA, TB, TC; otherwise TD.
  always_comb begin
    if (st.pending_mask[0]) k = 2'd0;
    else if (st.pending_mask[1]) k = 2'd1;
    else if (st.pending_mask[2]) k = 2'd2;
    else k = 2'd3;
    mask_clr = st.pending_mask & ~(4'd1 << k);
  end

  always_comb begin
    st_nxt = st;
    res = '0;
    res.byte_class = CL_TS;
    res.error_code = ERR_OK;
    if (!in_word.card_present) begin
      st_nxt = idle_st;
      res.error_code = ERR_REMOVED;
    end else if (in_word.first_byte) begin
      st_nxt = idle_st;
      st_nxt.phase = PH_T0;
      st_nxt.byte_count = IDX_W'(1);
    end else if (st.phase == PH_IDLE || st.phase > PH_CHECK) begin
      res.error_code = ERR_OUTSIDE;
    end else if (st.byte_count >= MaxIdx) begin
      st_nxt = idle_st;
      res.byte_index = st.byte_count;
      res.error_code = ERR_OVERFLOW;
    end else begin
      st_nxt.byte_count = st.byte_count + IDX_W'(1);
      res.byte_index = st.byte_count;
      case (st.phase)
        PH_T0: begin
          st_nxt.pending_mask = hi_nib;
          st_nxt.hist_left = lo_nib;
          st_nxt.group_level = 4'd1;
          st_nxt.phase = next_phase(hi_nib, lo_nib);
          res.byte_class = CL_T0;
        end
        PH_IFACE: begin
          res.byte_class = CL_TA + {1'b0, k};
          res.interface_level = st.group_level;
          if (k == 2'd3) begin
            st_nxt.pending_mask = hi_nib;
            if (st.group_level < LEVEL_MAX) st_nxt.group_level = st.group_level + 4'd1;
            st_nxt.phase = next_phase(hi_nib, st.hist_left);
          end else begin
            st_nxt.pending_mask = mask_clr;
            st_nxt.phase = next_phase(mask_clr, st.hist_left);
          end
        end
        PH_HIST: begin
          res.byte_class = CL_HIST;
          if (st.hist_left != 4'd0) begin
            st_nxt.hist_left = st.hist_left - 4'd1;
            st_nxt.phase = next_phase(st.pending_mask, st.hist_left - 4'd1);
          end else begin
            st_nxt.phase = next_phase(st.pending_mask, st.hist_left);
          end
        end
        default: begin
          st_nxt = idle_st;
          res.byte_class = CL_CHECK;
          res.byte_index = st.byte_count;
          res.atr_done = 1'b1;
        end
      endcase
    end
  end

endmodule

// File: rtl/atr_checker.sv
// Port-level assertions for the ATR structure parser, bound to the top level.
// Depends on atr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module atr_checker
  import atr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input atr_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input atr_out_t out_data
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `ASSERT_IMPL(a_ready_free, clk, rst_n, !out_valid, in_ready, "input stalled with empty result slot")
  `ASSERT_NEXT(a_removed, clk, rst_n, in_valid && in_ready && !in_data.card_present, out_valid && out_data.error_code == ERR_REMOVED, "card removal not reported")
  `ASSERT_IMPL(a_done_check, clk, rst_n, out_valid && out_data.atr_done, out_data.byte_class == CL_CHECK && out_data.error_code == ERR_OK, "done on a non-check byte")
  `ASSERT_IMPL(a_err_clean, clk, rst_n, out_valid && out_data.error_code != ERR_OK, out_data.byte_class == CL_TS && out_data.interface_level == 4'd0 && !out_data.atr_done, "error result carries a label")

endmodule

bind atr_structure_parser atr_checker u_atr_checker (.*);

// File: tb/sv/atr_structure_parser_tb.sv
// Self-checking bench for atr_structure_parser: drives ATR byte words, labels
// each one with an own parser model and compares every label field by field.
// Depends on atr_pkg and the atr_structure_parser RTL; nothing else.
module atr_structure_parser_tb
  import atr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_BYTES   = MAX_ATR_BYTES_DEF;
  localparam int unsigned RANDOM_WORDS = 1900;

  // Label board: shadows the parse state, holds the labels still owed by the
  // block and checks each one that comes out.
  class atr_label_board;
    logic [2:0]       phase;
    logic [3:0]       pending;
    logic [3:0]       hist_left;
    logic [IDX_W-1:0] count;
    logic [3:0]       level;
    atr_out_t         expected_labels[$];
    int unsigned      faults;
    int unsigned      checked;
    int unsigned      done_seen;
    int unsigned      err_seen[4];
    logic [3:0]       top_level;

    function new();
      go_idle();
      faults    = 0;
      checked   = 0;
      done_seen = 0;
      top_level = 4'd0;
      foreach (err_seen[i]) err_seen[i] = 0;
    endfunction

    function void go_idle();
      phase     = PH_IDLE;
      pending   = 4'd0;
      hist_left = 4'd0;
      count     = '0;
      level     = 4'd0;
    endfunction

    function void pick_phase();
      if (pending != 4'd0) phase = PH_IFACE;
      else if (hist_left != 4'd0) phase = PH_HIST;
      else phase = PH_CHECK;
    endfunction

    // Label one accepted byte and advance the parse state.
    function atr_out_t label_byte(atr_in_t w);
      atr_out_t         r;
      logic [IDX_W-1:0] idx;
      r = '0;
      idx = count;
      if (!w.card_present) begin
        go_idle();
        r.error_code = ERR_REMOVED;
      end else if (w.first_byte) begin
        go_idle();
        phase = PH_T0;
        count = IDX_W'(1);
        r.byte_class = CL_TS;
      end else if (phase == PH_IDLE || phase > PH_CHECK) begin
        r.error_code = ERR_OUTSIDE;
      end else if (idx >= MAX_BYTES) begin
        go_idle();
        r.byte_index = idx;
        r.error_code = ERR_OVERFLOW;
      end else begin
        count = idx + 1'b1;
        r.byte_index = idx;
        case (phase)
          PH_T0: begin
            pending   = w.rx_byte[7:4];
            hist_left = w.rx_byte[3:0];
            level     = 4'd1;
            r.byte_class = CL_T0;
            pick_phase();
          end
          PH_IFACE: begin
            r.interface_level = level;
            // TA, TB, TC go out in that order; TD closes the group.
            if (pending[0]) begin
              r.byte_class = CL_TA;
              pending[0] = 1'b0;
            end else if (pending[1]) begin
              r.byte_class = CL_TB;
              pending[1] = 1'b0;
            end else if (pending[2]) begin
              r.byte_class = CL_TC;
              pending[2] = 1'b0;
            end else begin
              r.byte_class = CL_TD;
              pending = w.rx_byte[7:4];
              if (level != LEVEL_MAX) level = level + 1'b1;
            end
            pick_phase();
          end
          PH_HIST: begin
            if (hist_left != 4'd0) hist_left = hist_left - 1'b1;
            r.byte_class = CL_HIST;
            pick_phase();
          end
          default: begin
            go_idle();
            r.byte_class = CL_CHECK;
            r.atr_done = 1'b1;
          end
        endcase
      end
      return r;
    endfunction

    function void note_byte(atr_in_t w);
      expected_labels.push_back(label_byte(w));
    endfunction

    function void check_label(atr_out_t got);
      atr_out_t want;
      if (expected_labels.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: label with none owed: class %0d lvl %0d idx %0d done %0b err %0d",
                   $realtime, got.byte_class, got.interface_level, got.byte_index,
                   got.atr_done, got.error_code);
        return;
      end
      want = expected_labels.pop_front();
      checked++;
      if (got.byte_class !== want.byte_class ||
          got.interface_level !== want.interface_level ||
          got.byte_index !== want.byte_index ||
          got.atr_done !== want.atr_done ||
          got.error_code !== want.error_code) begin
        faults++;
        if (faults <= 10)
          $display("%0t: label mismatch: want class %0d lvl %0d idx %0d done %0b err %0d, got class %0d lvl %0d idx %0d done %0b err %0d",
                   $realtime, want.byte_class, want.interface_level, want.byte_index,
                   want.atr_done, want.error_code, got.byte_class, got.interface_level,
                   got.byte_index, got.atr_done, got.error_code);
      end
      if (want.atr_done) done_seen++;
      err_seen[want.error_code]++;
      if (want.interface_level > top_level) top_level = want.interface_level;
    endfunction

    function int unsigned owed();
      return expected_labels.size();
    endfunction
  endclass

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  atr_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  atr_out_t out_data;

  // Idle odds in percent, set per phase of the run.
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  atr_in_t        atr_plan[$];
  atr_label_board board = new();
  int unsigned    words_sent = 0;

  atr_structure_parser #(
    .MAX_ATR_BYTES(MAX_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: stall at random with the odds of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Watch both handshakes at the edge; note the input word before checking,
  // so a label never races its own expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_byte(in_data);
      if (out_valid && out_ready) board.check_label(out_data);
    end
  end

  function automatic atr_in_t word_of(logic [7:0] b, logic first, logic present);
    atr_in_t w;
    w.rx_byte      = b;
    w.first_byte   = first;
    w.card_present = present;
    return w;
  endfunction

  // Plan one ATR with random content. Most are well formed; some run a long
  // TD chain into the length limit, some get cut by a card removal or an
  // early TS, and a few are plain noise.
  function automatic void plan_atr();
    int unsigned shape;
    int unsigned start;
    int unsigned cut;
    logic        chain;
    logic [7:0]  b;
    logic [3:0]  mask;
    logic [3:0]  hist;
    shape = $urandom_range(0, 99);
    start = atr_plan.size();
    chain = (shape < 6);
    if (shape >= 94) begin
      repeat ($urandom_range(1, 4))
        atr_plan.push_back(word_of(8'($urandom), 1'($urandom_range(0, 1)),
                                   $urandom_range(0, 7) != 0));
      return;
    end
    atr_plan.push_back(word_of(8'($urandom), 1'b1, 1'b1));
    b = 8'($urandom);
    if (chain) b[7] = 1'b1;
    atr_plan.push_back(word_of(b, 1'b0, 1'b1));
    mask = b[7:4];
    hist = b[3:0];
    // Walk the interface groups; cap the length well past the limit.
    while (mask != 4'd0 && atr_plan.size() - start < 40) begin
      for (int k = 0; k < 3; k++)
        if (mask[k]) atr_plan.push_back(word_of(8'($urandom), 1'b0, 1'b1));
      if (mask[3]) begin
        b = 8'($urandom);
        if (chain) b[7] = 1'b1;
        else if ($urandom_range(0, 1)) b[7] = 1'b0;
        atr_plan.push_back(word_of(b, 1'b0, 1'b1));
        mask = b[7:4];
      end else begin
        mask = 4'd0;
      end
    end
    repeat (hist) atr_plan.push_back(word_of(8'($urandom), 1'b0, 1'b1));
    atr_plan.push_back(word_of(8'($urandom), 1'b0, 1'b1));
    cut = $urandom_range(start + 1, atr_plan.size() - 1);
    if (shape >= 80 && shape < 88) begin
      atr_plan[cut].card_present = 1'b0;
      atr_plan[cut].first_byte   = 1'($urandom_range(0, 1));
    end else if (shape >= 88) begin
      atr_plan[cut].first_byte = 1'b1;
    end
    // Trail a stray byte or two past the end now and then.
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 2)) atr_plan.push_back(word_of(8'($urandom), 1'b0, 1'b1));
  endfunction

  // Offer one word, idling first at random; hold it until taken.
  task automatic send_byte(atr_in_t w);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_plan();
    while (atr_plan.size() != 0) send_byte(atr_plan.pop_front());
  endtask

  initial begin
    int unsigned phase_start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 6;
    recv_idle = 49;

    // Directed: a stray byte after reset, removal with and without TS.
    atr_plan.push_back(word_of(8'hA5, 1'b0, 1'b1));
    atr_plan.push_back(word_of(8'hFF, 1'b1, 1'b0));
    atr_plan.push_back(word_of(8'h00, 1'b0, 1'b0));
    // Shortest ATR, then a byte past its check byte.
    atr_plan.push_back(word_of(8'h3B, 1'b1, 1'b1));
    atr_plan.push_back(word_of(8'h00, 1'b0, 1'b1));
    atr_plan.push_back(word_of(8'h00, 1'b0, 1'b1));
    atr_plan.push_back(word_of(8'h5A, 1'b0, 1'b1));
    // Full first group, TD1 announcing nothing, two historical bytes.
    atr_plan.push_back(word_of(8'h3F, 1'b1, 1'b1));
    atr_plan.push_back(word_of(8'hF2, 1'b0, 1'b1));
    atr_plan.push_back(word_of(8'h11, 1'b0, 1'b1));
    atr_plan.push_back(word_of(8'h00, 1'b0, 1'b1));
    atr_plan.push_back(word_of(8'hFF, 1'b0, 1'b1));
    atr_plan.push_back(word_of(8'h00, 1'b0, 1'b1));
    atr_plan.push_back(word_of(8'h80, 1'b0, 1'b1));
    atr_plan.push_back(word_of(8'h7F, 1'b0, 1'b1));
    atr_plan.push_back(word_of(8'hFF, 1'b0, 1'b1));
    // TS mid-parse restarts; a second group opens, then the card is pulled.
    atr_plan.push_back(word_of(8'h3B, 1'b1, 1'b1));
    atr_plan.push_back(word_of(8'h1F, 1'b0, 1'b1));
    atr_plan.push_back(word_of(8'h96, 1'b0, 1'b1));
    atr_plan.push_back(word_of(8'h3B, 1'b1, 1'b1));
    atr_plan.push_back(word_of(8'h81, 1'b0, 1'b1));
    atr_plan.push_back(word_of(8'h80, 1'b0, 1'b1));
    atr_plan.push_back(word_of(8'h00, 1'b0, 1'b0));
    send_plan();

    // Random ATRs in three stretches: sender idling lightly, then the
    // receiver idling lightly, then no idling at all.
    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 6 : (p == 1) ? 49 : 0;
      recv_idle = (p == 0) ? 49 : (p == 1) ? 6 : 0;
      phase_start = words_sent;
      while (words_sent - phase_start < RANDOM_WORDS / 3) begin
        plan_atr();
        send_plan();
      end
    end
    in_valid <= 1'b0;

    // Drain: wait until no label is owed, then let spare edges pass.
    while (board.owed() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d byte words, checked %0d labels, %0d complete ATRs, deepest level %0d.",
             words_sent, board.checked, board.done_seen, board.top_level);
    $display("Flagged: %0d overflows, %0d removals, %0d stray bytes; %0d mismatches.",
             board.err_seen[ERR_OVERFLOW], board.err_seen[ERR_REMOVED],
             board.err_seen[ERR_OUTSIDE], board.faults);
    if (board.faults == 0 && board.owed() == 0) begin
      $display("PASS atr_structure_parser");
    end else begin
      $display("FAIL atr_structure_parser");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest honest run.
  initial begin
    #1ms;
    $display("FAIL atr_structure_parser");
    $finish;
  end

endmodule
